[src/obbsat_pkg.sv]
package obbsat_pkg;

  // Default width of one packed vector component.
  localparam int COMPONENT_BITS_DEF = 20;
  // Width of one input field holding three packed components.
  localparam int FIELD_BITS = 60;
  // Number of input fields in one input word.
  localparam int FIELD_COUNT = 10;
  // Fraction bits of a unit axis.
  localparam int AXIS_FRAC = 18;
  // Number of candidate axes.
  localparam int AXIS_COUNT = 15;

  // Field positions inside the input word.
  localparam int F_A_CENTER = 0;
  localparam int F_A_EXT    = 1;
  localparam int F_A_AXIS   = 2;
  localparam int F_B_CENTER = 5;
  localparam int F_B_EXT    = 6;
  localparam int F_B_AXIS   = 7;

  // Width of a candidate axis component: face axes keep the input width,
  // rounded cross products may need a few more bits.
  function automatic int axis_bits(input int w);
    return (2 * w - 16 > w) ? 2 * w - 16 : w;
  endfunction

endpackage

[src/obbsat_cross.sv]
module obbsat_cross
  import obbsat_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           en,
  input  logic signed [COMPONENT_BITS-1:0]               a [3],
  input  logic signed [COMPONENT_BITS-1:0]               b [3],
  output logic signed [axis_bits(COMPONENT_BITS)-1:0]    l [3]
);

  localparam int W   = COMPONENT_BITS;
  localparam int LW  = axis_bits(COMPONENT_BITS);
  localparam int PW  = 2 * W;
  localparam int DFW = 2 * W + 1;
  localparam int RW  = DFW + 1 - AXIS_FRAC;
  localparam logic [DFW:0] HALF = (DFW + 1)'(1) << (AXIS_FRAC - 1);

  logic signed [PW-1:0]  prod_r [6];
  logic signed [DFW-1:0] diff   [3];
  logic [DFW-1:0]        mag    [3];
  logic [DFW:0]          rnd    [3];
  logic signed [LW-1:0]  l_nxt  [3];
  logic signed [LW-1:0]  l_r    [3];

  // First stage: the six partial products of the cross product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= PW'(a[1]) * PW'(b[2]);
      prod_r[1] <= PW'(a[2]) * PW'(b[1]);
      prod_r[2] <= PW'(a[2]) * PW'(b[0]);
      prod_r[3] <= PW'(a[0]) * PW'(b[2]);
      prod_r[4] <= PW'(a[0]) * PW'(b[1]);
      prod_r[5] <= PW'(a[1]) * PW'(b[0]);
    end
  end

  // Second stage: difference, then round half away from zero to the axis format.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = DFW'(prod_r[2*k]) - DFW'(prod_r[2*k+1]);
      mag[k]   = diff[k][DFW-1] ? DFW'(-diff[k]) : DFW'(diff[k]);
      rnd[k]   = {1'b0, mag[k]} + HALF;
      l_nxt[k] = diff[k][DFW-1] ? -$signed(LW'(rnd[k][DFW:AXIS_FRAC]))
                                :  $signed(LW'(rnd[k][DFW:AXIS_FRAC]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_nxt;
    end
  end

  assign l = l_r;

  // Rounded width never exceeds the axis width.
  localparam int UNUSED_RW = RW;

endmodule

[src/obbsat_axis.sv]
module obbsat_axis
  import obbsat_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic signed [axis_bits(COMPONENT_BITS)-1:0]  l  [3],
  input  logic signed [COMPONENT_BITS-1:0]             aa [3][3],
  input  logic signed [COMPONENT_BITS-1:0]             ab [3][3],
  input  logic signed [COMPONENT_BITS-1:0]             ea [3],
  input  logic signed [COMPONENT_BITS-1:0]             eb [3],
  input  logic signed [COMPONENT_BITS:0]               d  [3],
  output logic                                         sep
);

  localparam int W    = COMPONENT_BITS;
  localparam int LW   = axis_bits(COMPONENT_BITS);
  localparam int PW   = W + LW;
  localparam int SW   = PW + 2;
  localparam int RW   = SW + 1 - AXIS_FRAC;
  localparam int QW   = W + 1 + LW;
  localparam int DSW  = QW + 2;
  localparam int TW   = W + RW;
  localparam int RSW  = TW + 3;
  localparam int CMPW = (DSW > RSW) ? DSW : RSW;
  localparam logic [SW:0] HALF = (SW + 1)'(1) << (AXIS_FRAC - 1);

  logic signed [QW-1:0]  pd_r   [3];
  logic signed [PW-1:0]  pa_r   [3][3];
  logic signed [PW-1:0]  pb_r   [3][3];
  logic [W-1:0]          ema_r  [3];
  logic [W-1:0]          emb_r  [3];

  logic signed [DSW-1:0] dsum;
  logic [DSW-1:0]        dist_nxt;
  logic signed [SW-1:0]  sa     [3];
  logic signed [SW-1:0]  sb     [3];
  logic [SW-1:0]         ma     [3];
  logic [SW-1:0]         mb     [3];
  logic [SW:0]           rna    [3];
  logic [SW:0]           rnb    [3];
  logic [DSW-1:0]        dist_r;
  logic [RW-1:0]         ra_r   [3];
  logic [RW-1:0]         rb_r   [3];
  logic [W-1:0]          ema2_r [3];
  logic [W-1:0]          emb2_r [3];

  logic [TW-1:0]         ta_r   [3];
  logic [TW-1:0]         tb_r   [3];
  logic [DSW-1:0]        dist3_r;

  logic [RSW-1:0]        rsum;
  logic                  sep_r;

  // Stage one: all projection products and the extent magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pd_r[k]  <= QW'(d[k]) * QW'(l[k]);
        ema_r[k] <= ea[k][W-1] ? W'(-ea[k]) : W'(ea[k]);
        emb_r[k] <= eb[k][W-1] ? W'(-eb[k]) : W'(eb[k]);
        for (int i = 0; i < 3; i++) begin
          pa_r[i][k] <= PW'(aa[i][k]) * PW'(l[k]);
          pb_r[i][k] <= PW'(ab[i][k]) * PW'(l[k]);
        end
      end
    end
  end

  // Stage two: dot product sums, magnitudes and rounding of the axis projections.
  always_comb begin
    dsum     = DSW'(pd_r[0]) + DSW'(pd_r[1]) + DSW'(pd_r[2]);
    dist_nxt = dsum[DSW-1] ? DSW'(-dsum) : DSW'(dsum);
    for (int i = 0; i < 3; i++) begin
      sa[i]  = SW'(pa_r[i][0]) + SW'(pa_r[i][1]) + SW'(pa_r[i][2]);
      sb[i]  = SW'(pb_r[i][0]) + SW'(pb_r[i][1]) + SW'(pb_r[i][2]);
      ma[i]  = sa[i][SW-1] ? SW'(-sa[i]) : SW'(sa[i]);
      mb[i]  = sb[i][SW-1] ? SW'(-sb[i]) : SW'(sb[i]);
      rna[i] = {1'b0, ma[i]} + HALF;
      rnb[i] = {1'b0, mb[i]} + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      for (int i = 0; i < 3; i++) begin
        ra_r[i]   <= rna[i][SW:AXIS_FRAC];
        rb_r[i]   <= rnb[i][SW:AXIS_FRAC];
        ema2_r[i] <= ema_r[i];
        emb2_r[i] <= emb_r[i];
      end
    end
  end

  // Stage three: radius terms, extent times projected axis length.
  always_ff @(posedge clk) begin
    if (en) begin
      dist3_r <= dist_r;
      for (int i = 0; i < 3; i++) begin
        ta_r[i] <= TW'(ema2_r[i]) * TW'(ra_r[i]);
        tb_r[i] <= TW'(emb2_r[i]) * TW'(rb_r[i]);
      end
    end
  end

  // Stage four: the axis separates when the distance exceeds the sum of both radii.
  always_comb begin
    rsum = RSW'(ta_r[0]) + RSW'(ta_r[1]) + RSW'(ta_r[2])
         + RSW'(tb_r[0]) + RSW'(tb_r[1]) + RSW'(tb_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sep_r <= CMPW'(dist3_r) > CMPW'(rsum);
    end
  end

  assign sep = sep_r;

endmodule

[src/obb_obb_separating_axis_test_core.sv]
// Oriented box pair overlap test over fifteen candidate axes.
// Throughput: one word per cycle; the whole pipeline holds while a result
// word is waiting and out_tready is low.
// Stages: input register, two cross product stages, four projection stages, output.
// Reset clears only the stage valid bits; data registers are not reset.
module obb_obb_separating_axis_test_core
  import obbsat_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // a_center, a_half_extent, a_axis_x, a_axis_y, a_axis_z,
  // b_center, b_half_extent, b_axis_x, b_axis_y, b_axis_z (60 bits each)
  input  logic [FIELD_COUNT*FIELD_BITS-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // overlap in bit 0, zeros above
  output logic [7:0]                        out_tdata
);

  localparam int W     = COMPONENT_BITS;
  localparam int LW    = axis_bits(COMPONENT_BITS);
  localparam int DBITS = FIELD_COUNT * FIELD_BITS;
  localparam int DEPTH = 8;

  logic [DEPTH-1:0] vld_r;
  logic             adv;
  logic [DBITS-1:0] s0_r;
  logic [DBITS-1:0] s1_r;
  logic [DBITS-1:0] s2_r;

  logic signed [W-1:0]  aa0 [3][3];
  logic signed [W-1:0]  ab0 [3][3];
  logic signed [W-1:0]  aa2 [3][3];
  logic signed [W-1:0]  ab2 [3][3];
  logic signed [W-1:0]  ca2 [3];
  logic signed [W-1:0]  cb2 [3];
  logic signed [W-1:0]  ea2 [3];
  logic signed [W-1:0]  eb2 [3];
  logic signed [W:0]    d2  [3];
  logic signed [LW-1:0] cax [9][3];
  logic signed [LW-1:0] lax [AXIS_COUNT][3];
  logic [AXIS_COUNT-1:0] sep;
  logic                 overlap_r;

  // The pipeline moves whenever the output word is free or being taken.
  assign adv       = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // Input word and its two delayed copies, aligned with the cross products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= in_tdata;
      s1_r <= s0_r;
      s2_r <= s1_r;
    end
  end

  // Unpack the component slices.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        aa0[i][k] = s0_r[(F_A_AXIS+i)*FIELD_BITS + k*W +: W];
        ab0[i][k] = s0_r[(F_B_AXIS+i)*FIELD_BITS + k*W +: W];
        aa2[i][k] = s2_r[(F_A_AXIS+i)*FIELD_BITS + k*W +: W];
        ab2[i][k] = s2_r[(F_B_AXIS+i)*FIELD_BITS + k*W +: W];
      end
    end
    for (int k = 0; k < 3; k++) begin
      ca2[k] = s2_r[F_A_CENTER*FIELD_BITS + k*W +: W];
      cb2[k] = s2_r[F_B_CENTER*FIELD_BITS + k*W +: W];
      ea2[k] = s2_r[F_A_EXT*FIELD_BITS + k*W +: W];
      eb2[k] = s2_r[F_B_EXT*FIELD_BITS + k*W +: W];
      d2[k]  = (W+1)'(cb2[k]) - (W+1)'(ca2[k]);
    end
  end

  // Nine cross product axes.
  for (genvar g = 0; g < 9; g++) begin : g_cross
    obbsat_cross #(
      .COMPONENT_BITS(COMPONENT_BITS)
    ) u_cross (
      .clk(clk),
      .en (adv),
      .a  (aa0[g/3]),
      .b  (ab0[g%3]),
      .l  (cax[g])
    );
  end

  // Candidate axis list: A faces, B faces, then the cross products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        lax[i][k]   = LW'(aa2[i][k]);
        lax[3+i][k] = LW'(ab2[i][k]);
      end
      for (int j = 0; j < 9; j++) begin
        lax[6+j][k] = cax[j][k];
      end
    end
  end

  // One projection test per candidate axis.
  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
    obbsat_axis #(
      .COMPONENT_BITS(COMPONENT_BITS)
    ) u_axis (
      .clk(clk),
      .en (adv),
      .l  (lax[g]),
      .aa (aa2),
      .ab (ab2),
      .ea (ea2),
      .eb (eb2),
      .d  (d2),
      .sep(sep[g])
    );
  end

  // Output register: overlap unless some axis separates.
  always_ff @(posedge clk) begin
    if (adv) begin
      overlap_r <= ~|sep;
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {7'b0, overlap_r};

endmodule
